// File: design/complex_arithmetic_unit_defines.svh
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Check that post holds in the same cycle as pre.
`define CAU_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Check that post holds in the cycle after pre.
`define CAU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: design/cau_pkg.sv
`default_nettype none

package cau_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned PROD_W    = 2 * WORD_W;
  localparam int unsigned SUM_W     = PROD_W + 1;
  localparam int unsigned WIDE_W    = PROD_W + 2;
  localparam int unsigned ROOT_W    = PROD_W / 2;
  localparam int unsigned REM_W     = ROOT_W + 2;
  localparam int unsigned SQ_STEPS  = PROD_W / 2;
  localparam int unsigned QUO_W     = WORD_W + 1;
  localparam int unsigned NUM_W     = PROD_W + FRAC_W;
  localparam int unsigned HI_W      = NUM_W - QUO_W;
  localparam int unsigned DIV_STEPS = QUO_W;

  localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
  localparam logic [OP_W-1:0] OP_MAG  = 3'd4;
  localparam logic [OP_W-1:0] OP_SQRT = 3'd5;

  localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    logic [WORD_W-1:0] val;
    logic              flt;
  } cau_res_t;

  typedef struct packed {
    logic [WORD_W-1:0] re;
    logic [WORD_W-1:0] im;
    logic              flt;
  } cau_out_t;

  // One square root step: radicand bits still to shift in, remainder, root.
  typedef struct packed {
    logic [PROD_W-1:0] x;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } cau_sq_t;

  // One divider lane: partial remainder, divisor, dividend bits left, quotient.
  typedef struct packed {
    logic [PROD_W-1:0] r;
    logic [PROD_W-1:0] d;
    logic [QUO_W-1:0]  lo;
    logic [QUO_W-1:0]  q;
    logic              neg;
    logic              ovf;
  } cau_dl_t;

  // Per-word sideband carried along the cell chains.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] e_re;
    logic [WORD_W-1:0] e_im;
    logic              e_flt;
    logic              ar_neg;
    logic              ai_neg;
    logic [WORD_W-1:0] ax;
    logic [WORD_W-1:0] ay;
    logic [ROOT_W-1:0] m;
    logic [ROOT_W-1:0] w;
    logic              nr;
    logic              ni;
    logic [PROD_W-1:0] mr;
    logic [PROD_W-1:0] mi;
    logic [PROD_W-1:0] den;
    logic              den_zero;
  } cau_side_t;

  // Saturate a two's complement value to one word.
  function automatic cau_res_t sat_s(input logic [WIDE_W-1:0] v);
    cau_res_t r;
    logic     pos_ovf;
    logic     neg_ovf;
    pos_ovf = !v[WIDE_W-1] && (|v[WIDE_W-2:WORD_W-1]);
    neg_ovf = v[WIDE_W-1] && !(&v[WIDE_W-2:WORD_W-1]);
    r.flt = pos_ovf | neg_ovf;
    if (pos_ovf) begin
      r.val = SAT_MAX;
    end else if (neg_ovf) begin
      r.val = SAT_MIN;
    end else begin
      r.val = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Saturate a sign and magnitude pair to one word.
  function automatic cau_res_t sat_mag(input logic neg, input logic [WIDE_W-1:0] mag);
    cau_res_t          r;
    logic [WORD_W-1:0] lo;
    lo = mag[WORD_W-1:0];
    r.flt = 1'b0;
    if (neg) begin
      if ((|mag[WIDE_W-1:WORD_W]) || (mag[WORD_W-1] && (|mag[WORD_W-2:0]))) begin
        r.flt = 1'b1;
        r.val = SAT_MIN;
      end else begin
        r.val = -lo;
      end
    end else begin
      if (|mag[WIDE_W-1:WORD_W-1]) begin
        r.flt = 1'b1;
        r.val = SAT_MAX;
      end else begin
        r.val = lo;
      end
    end
    return r;
  endfunction

  // Final value of a divider lane, floored toward negative infinity.
  function automatic cau_res_t quo_res(input cau_dl_t l);
    cau_res_t          r;
    logic [WIDE_W-1:0] mag;
    logic              rnd;
    rnd = l.neg && (|l.r);
    mag = {{(WIDE_W-QUO_W){1'b0}}, l.q} + {{(WIDE_W-1){1'b0}}, rnd};
    if (l.ovf) begin
      r.flt = 1'b1;
      r.val = l.neg ? SAT_MIN : SAT_MAX;
    end else begin
      r = sat_mag(l.neg, mag);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/cau_in_if.sv
`default_nettype none

interface cau_in_if;
  logic                            valid;
  logic                            ready;
  logic [cau_pkg::OP_W-1:0]        op;
  logic signed [cau_pkg::WORD_W-1:0] a_re;
  logic signed [cau_pkg::WORD_W-1:0] a_im;
  logic signed [cau_pkg::WORD_W-1:0] b_re;
  logic signed [cau_pkg::WORD_W-1:0] b_im;

  modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

`default_nettype wire

// File: design/cau_out_if.sv
`default_nettype none

interface cau_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cau_pkg::WORD_W-1:0] res_re;
  logic signed [cau_pkg::WORD_W-1:0] res_im;
  logic                              fault;

  modport source (output valid, res_re, res_im, fault, input ready);
  modport sink   (input valid, res_re, res_im, fault, output ready);
endinterface

`default_nettype wire

// File: design/cau_sq_cell.sv
`default_nettype none

// One digit of an integer square root: two radicand bits in, one root bit out.
module cau_sq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  cau_pkg::cau_sq_t   sq_i,
  input  cau_pkg::cau_side_t side_i,
  output logic               vld_o,
  output cau_pkg::cau_sq_t   sq_o,
  output cau_pkg::cau_side_t side_o
);

  logic [cau_pkg::REM_W+1:0] cur;
  logic [cau_pkg::REM_W+1:0] trial;
  logic [cau_pkg::REM_W+1:0] diff;
  logic                      ge;
  cau_pkg::cau_sq_t          sq_d;
  cau_pkg::cau_sq_t          sq_q;
  cau_pkg::cau_side_t        side_q;
  logic                      vld_q;

  always_comb begin
    cur   = {sq_i.rem, sq_i.x[cau_pkg::PROD_W-1 -: 2]};
    trial = {2'b00, sq_i.root, 2'b01};
    diff  = cur - trial;
    ge    = cur >= trial;
    sq_d.x    = {sq_i.x[cau_pkg::PROD_W-3:0], 2'b00};
    sq_d.rem  = ge ? diff[cau_pkg::REM_W-1:0] : cur[cau_pkg::REM_W-1:0];
    sq_d.root = {sq_i.root[cau_pkg::ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= sq_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign sq_o   = sq_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

// File: design/cau_div_cell.sv
`default_nettype none

// One restoring division step on two lanes: one quotient bit per lane.
module cau_div_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  cau_pkg::cau_dl_t [1:0] dl_i,
  input  cau_pkg::cau_side_t     side_i,
  output logic                   vld_o,
  output cau_pkg::cau_dl_t [1:0] dl_o,
  output cau_pkg::cau_side_t     side_o
);

  logic [cau_pkg::SUM_W-1:0] t    [2];
  logic [cau_pkg::SUM_W-1:0] diff [2];
  logic                      ge   [2];
  cau_pkg::cau_dl_t [1:0]    dl_d;
  cau_pkg::cau_dl_t [1:0]    dl_q;
  cau_pkg::cau_side_t        side_q;
  logic                      vld_q;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      t[k]    = {dl_i[k].r, dl_i[k].lo[cau_pkg::QUO_W-1]};
      diff[k] = t[k] - {1'b0, dl_i[k].d};
      ge[k]   = t[k] >= {1'b0, dl_i[k].d};
      dl_d[k].r   = ge[k] ? diff[k][cau_pkg::PROD_W-1:0] : t[k][cau_pkg::PROD_W-1:0];
      dl_d[k].d   = dl_i[k].d;
      dl_d[k].lo  = {dl_i[k].lo[cau_pkg::QUO_W-2:0], 1'b0};
      dl_d[k].q   = {dl_i[k].q[cau_pkg::QUO_W-2:0], ge[k]};
      dl_d[k].neg = dl_i[k].neg;
      dl_d[k].ovf = dl_i[k].ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dl_q   <= dl_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign dl_o   = dl_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

// File: design/complex_arithmetic_unit.sv
// Throughput: one word per cycle while the skid word is empty (all stages stall
// while it is held); the pipeline holds two 32-cell square root chains and a
// 33-cell two-lane divider chain, all advancing together.
// A two-entry output buffer keeps req_i ready while one result waits.
// Reset (rst_ni low, asynchronous) empties the pipeline and the output buffer.
`default_nettype none
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  cau_in_if.sink            req_i,
  cau_out_if.source         rsp_o
);

  localparam int unsigned W  = cau_pkg::WORD_W;
  localparam int unsigned PW = cau_pkg::PROD_W;
  localparam int unsigned SW = cau_pkg::SUM_W;
  localparam int unsigned XW = cau_pkg::WIDE_W;
  localparam int unsigned NS = cau_pkg::SQ_STEPS;
  localparam int unsigned ND = cau_pkg::DIV_STEPS;

  logic adv;
  logic skid_vld_q, skid_vld_d;
  logic out_vld_q, out_vld_d;
  cau_pkg::cau_out_t out_q, out_d, skid_q, skid_d, fin;
  logic fin_vld;

  assign adv         = !skid_vld_q;
  assign req_i.ready = adv;

  // Stage 1: products and add/sub
  logic [PW-1:0] p1_d, p2_d, p3_d, p4_d, qbr_d, qbi_d, qar_d, qai_d;
  logic [PW-1:0] p1_q, p2_q, p3_q, p4_q, qbr_q, qbi_q, qar_q, qai_q;
  logic [W:0]    as_re, as_im;
  cau_pkg::cau_res_t e1re_d, e1im_d, e1re_q, e1im_q;
  logic [cau_pkg::OP_W-1:0] s1_op_q;
  logic [W-1:0]  s1_ar_q, s1_ai_q;
  logic          s1_vld_q;

  assign p1_d  = req_i.a_re * req_i.b_re;
  assign p2_d  = req_i.a_im * req_i.b_im;
  assign p3_d  = req_i.a_re * req_i.b_im;
  assign p4_d  = req_i.a_im * req_i.b_re;
  assign qbr_d = req_i.b_re * req_i.b_re;
  assign qbi_d = req_i.b_im * req_i.b_im;
  assign qar_d = req_i.a_re * req_i.a_re;
  assign qai_d = req_i.a_im * req_i.a_im;

  always_comb begin
    if (req_i.op == cau_pkg::OP_SUB) begin
      as_re = {req_i.a_re[W-1], req_i.a_re} - {req_i.b_re[W-1], req_i.b_re};
      as_im = {req_i.a_im[W-1], req_i.a_im} - {req_i.b_im[W-1], req_i.b_im};
    end else begin
      as_re = {req_i.a_re[W-1], req_i.a_re} + {req_i.b_re[W-1], req_i.b_re};
      as_im = {req_i.a_im[W-1], req_i.a_im} + {req_i.b_im[W-1], req_i.b_im};
    end
    e1re_d = cau_pkg::sat_s({{(XW-W-1){as_re[W]}}, as_re});
    e1im_d = cau_pkg::sat_s({{(XW-W-1){as_im[W]}}, as_im});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q <= p1_d;  p2_q <= p2_d;  p3_q <= p3_d;  p4_q <= p4_d;
      qbr_q <= qbr_d; qbi_q <= qbi_d; qar_q <= qar_d; qai_q <= qai_d;
      e1re_q <= e1re_d; e1im_q <= e1im_d;
      s1_op_q <= req_i.op;
      s1_ar_q <= req_i.a_re;
      s1_ai_q <= req_i.a_im;
    end
  end

  // Stage 2: sums, multiply result, divider numerators, squared magnitude
  logic [SW-1:0] dre, dim, nsr, nsi, nsr_n, nsi_n, dre_s, dim_s;
  cau_pkg::cau_res_t mre, mim;
  cau_pkg::cau_side_t s2_side_d, s2_side_q;
  cau_pkg::cau_sq_t   s2_sq_d, s2_sq_q;
  logic               s2_vld_q;

  always_comb begin
    dre   = {p1_q[PW-1], p1_q} - {p2_q[PW-1], p2_q};
    dim   = {p3_q[PW-1], p3_q} + {p4_q[PW-1], p4_q};
    dre_s = {{cau_pkg::FRAC_W{dre[SW-1]}}, dre[SW-1:cau_pkg::FRAC_W]};
    dim_s = {{cau_pkg::FRAC_W{dim[SW-1]}}, dim[SW-1:cau_pkg::FRAC_W]};
    mre   = cau_pkg::sat_s({{(XW-SW){dre_s[SW-1]}}, dre_s});
    mim   = cau_pkg::sat_s({{(XW-SW){dim_s[SW-1]}}, dim_s});
    nsr   = {p1_q[PW-1], p1_q} + {p2_q[PW-1], p2_q};
    nsi   = {p4_q[PW-1], p4_q} - {p3_q[PW-1], p3_q};
    nsr_n = -nsr;
    nsi_n = -nsi;

    s2_side_d.op     = s1_op_q;
    s2_side_d.ar_neg = s1_ar_q[W-1];
    s2_side_d.ai_neg = s1_ai_q[W-1];
    s2_side_d.ax     = s1_ar_q[W-1] ? -s1_ar_q : s1_ar_q;
    s2_side_d.ay     = s1_ai_q[W-1] ? -s1_ai_q : s1_ai_q;
    s2_side_d.m      = '0;
    s2_side_d.w      = '0;
    s2_side_d.nr     = nsr[SW-1];
    s2_side_d.ni     = nsi[SW-1];
    s2_side_d.mr     = nsr[SW-1] ? nsr_n[PW-1:0] : nsr[PW-1:0];
    s2_side_d.mi     = nsi[SW-1] ? nsi_n[PW-1:0] : nsi[PW-1:0];
    s2_side_d.den    = qbr_q + qbi_q;
    s2_side_d.den_zero = (qbr_q == '0) && (qbi_q == '0);
    case (s1_op_q)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        s2_side_d.e_re  = e1re_q.val;
        s2_side_d.e_im  = e1im_q.val;
        s2_side_d.e_flt = e1re_q.flt | e1im_q.flt;
      end
      cau_pkg::OP_MUL: begin
        s2_side_d.e_re  = mre.val;
        s2_side_d.e_im  = mim.val;
        s2_side_d.e_flt = mre.flt | mim.flt;
      end
      default: begin
        s2_side_d.e_re  = '0;
        s2_side_d.e_im  = '0;
        s2_side_d.e_flt = 1'b0;
      end
    endcase
    s2_sq_d.x    = qar_q + qai_q;
    s2_sq_d.rem  = '0;
    s2_sq_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_side_q <= s2_side_d;
      s2_sq_q   <= s2_sq_d;
    end
  end

  // Chain 1: m = isqrt(ar^2 + ai^2)
  logic               c1_vld  [NS+1];
  cau_pkg::cau_sq_t   c1_sq   [NS+1];
  cau_pkg::cau_side_t c1_side [NS+1];

  assign c1_vld[0]  = s2_vld_q;
  assign c1_sq[0]   = s2_sq_q;
  assign c1_side[0] = s2_side_q;

  for (genvar g = 0; g < NS; g++) begin : g_c1
    cau_sq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (c1_vld[g]),
      .sq_i   (c1_sq[g]),
      .side_i (c1_side[g]),
      .vld_o  (c1_vld[g+1]),
      .sq_o   (c1_sq[g+1]),
      .side_o (c1_side[g+1])
    );
  end

  // Chain 2: w = isqrt((|ar| + m) * 2^(F-1))
  logic               c2_vld  [NS+1];
  cau_pkg::cau_sq_t   c2_sq   [NS+1];
  cau_pkg::cau_side_t c2_side [NS+1];
  logic [W:0]         axm;

  always_comb begin
    axm         = {1'b0, c1_side[NS].ax} + {1'b0, c1_sq[NS].root};
    c2_side[0]   = c1_side[NS];
    c2_side[0].m = c1_sq[NS].root;
    c2_sq[0].x   = {{(PW-W-cau_pkg::FRAC_W){1'b0}}, axm, {(cau_pkg::FRAC_W-1){1'b0}}};
    c2_sq[0].rem  = '0;
    c2_sq[0].root = '0;
  end
  assign c2_vld[0] = c1_vld[NS];

  for (genvar g = 0; g < NS; g++) begin : g_c2
    cau_sq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (c2_vld[g]),
      .sq_i   (c2_sq[g]),
      .side_i (c2_side[g]),
      .vld_o  (c2_vld[g+1]),
      .sq_o   (c2_sq[g+1]),
      .side_o (c2_side[g+1])
    );
  end

  // Divider load: lane 0 serves the real quotient or the root quotient
  logic [cau_pkg::NUM_W-1:0] num [2];
  logic [PW-1:0]             dvs [2];
  logic                      lneg [2];
  cau_pkg::cau_dl_t [1:0]    ld_dl_d, ld_dl_q;
  cau_pkg::cau_side_t        ld_side_d, ld_side_q;
  logic                      ld_vld_q;
  logic [PW-1:0]             hi_ext [2];

  always_comb begin
    ld_side_d   = c2_side[NS];
    ld_side_d.w = c2_sq[NS].root;
    if (c2_side[NS].op == cau_pkg::OP_SQRT) begin
      num[0]  = {{(cau_pkg::NUM_W-W-cau_pkg::FRAC_W){1'b0}}, c2_side[NS].ay,
                 {cau_pkg::FRAC_W{1'b0}}};
      dvs[0]  = {{(PW-cau_pkg::ROOT_W-1){1'b0}}, c2_sq[NS].root, 1'b0};
      lneg[0] = c2_side[NS].ai_neg && !c2_side[NS].ar_neg;
    end else begin
      num[0]  = {c2_side[NS].mr, {cau_pkg::FRAC_W{1'b0}}};
      dvs[0]  = c2_side[NS].den;
      lneg[0] = c2_side[NS].nr;
    end
    num[1]  = {c2_side[NS].mi, {cau_pkg::FRAC_W{1'b0}}};
    dvs[1]  = c2_side[NS].den;
    lneg[1] = c2_side[NS].ni;
    for (int k = 0; k < 2; k++) begin
      hi_ext[k]      = {{(PW-cau_pkg::HI_W){1'b0}}, num[k][cau_pkg::NUM_W-1:cau_pkg::QUO_W]};
      ld_dl_d[k].r   = hi_ext[k];
      ld_dl_d[k].d   = dvs[k];
      ld_dl_d[k].lo  = num[k][cau_pkg::QUO_W-1:0];
      ld_dl_d[k].q   = '0;
      ld_dl_d[k].neg = lneg[k];
      // quotient would not fit the step count: saturate
      ld_dl_d[k].ovf = hi_ext[k] >= dvs[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_vld_q <= 1'b0;
    end else if (adv) begin
      ld_vld_q <= c2_vld[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ld_dl_q   <= ld_dl_d;
      ld_side_q <= ld_side_d;
    end
  end

  // Chain 3: two-lane restoring divider
  logic                   dv_vld  [ND+1];
  cau_pkg::cau_dl_t [1:0] dv_dl   [ND+1];
  cau_pkg::cau_side_t     dv_side [ND+1];

  assign dv_vld[0]  = ld_vld_q;
  assign dv_dl[0]   = ld_dl_q;
  assign dv_side[0] = ld_side_q;

  for (genvar g = 0; g < ND; g++) begin : g_dv
    cau_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (dv_vld[g]),
      .dl_i   (dv_dl[g]),
      .side_i (dv_side[g]),
      .vld_o  (dv_vld[g+1]),
      .dl_o   (dv_dl[g+1]),
      .side_o (dv_side[g+1])
    );
  end

  // Result select
  cau_pkg::cau_side_t sd;
  cau_pkg::cau_res_t  q0, q1, rm, rw;

  always_comb begin
    sd = dv_side[ND];
    q0 = cau_pkg::quo_res(dv_dl[ND][0]);
    q1 = cau_pkg::quo_res(dv_dl[ND][1]);
    rm = cau_pkg::sat_mag(1'b0, {{(XW-cau_pkg::ROOT_W){1'b0}}, sd.m});
    rw = cau_pkg::sat_mag(1'b0, {{(XW-cau_pkg::ROOT_W){1'b0}}, sd.w});
    fin = '0;
    case (sd.op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
        fin.re  = sd.e_re;
        fin.im  = sd.e_im;
        fin.flt = sd.e_flt;
      end
      cau_pkg::OP_DIV: begin
        if (sd.den_zero) begin
          fin.flt = 1'b1;
        end else begin
          fin.re  = q0.val;
          fin.im  = q1.val;
          fin.flt = q0.flt | q1.flt;
        end
      end
      cau_pkg::OP_MAG: begin
        fin.re  = rm.val;
        fin.flt = rm.flt;
      end
      cau_pkg::OP_SQRT: begin
        if (sd.ax == '0 && sd.ay == '0) begin
          fin = '0;
        end else if (!sd.ar_neg) begin
          fin.re  = rw.val;
          fin.im  = q0.val;
          fin.flt = rw.flt | q0.flt;
        end else begin
          fin.re  = q0.val;
          fin.im  = sd.ai_neg ? -sd.w : sd.w;
          fin.flt = q0.flt;
        end
      end
      default: begin
        fin = '0;
      end
    endcase
  end
  assign fin_vld = dv_vld[ND];

  // Output word plus skid word
  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (rsp_o.ready) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (!out_vld_q || rsp_o.ready) begin
      out_vld_d = fin_vld;
      out_d     = fin;
    end else if (fin_vld) begin
      // hold the new word aside while the output word waits
      skid_vld_d = 1'b1;
      skid_d     = fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.res_re = out_q.re;
  assign rsp_o.res_im = out_q.im;
  assign rsp_o.fault  = out_q.flt;

  `CAU_ASSERT_NOW(a_skid_has_out, skid_vld_q, out_vld_q, "skid word without output word")
  `CAU_ASSERT_NEXT(a_skid_fill, out_vld_q && !rsp_o.ready && !skid_vld_q && fin_vld, skid_vld_q, "stalled result word lost")
  `CAU_ASSERT_NEXT(a_skid_hold, skid_vld_q && !rsp_o.ready, skid_vld_q && $stable(skid_q), "skid word changed while stalled")

endmodule

`default_nettype wire
